### hdl/bta_pkg.sv
// ----------------------------------------------------------------------------
// bta_pkg - shared types for the block table allocator
// request and response structs, op and status codes, cell chain record
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned HEAP_BYTES_DEF    = 65536;
  localparam logic [31:0] HEAP_BASE_DEF     = 32'h0010_0000;

  // wide enough for a slot of the largest table
  localparam int unsigned SLOT_W = 8;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [16:0] req_size;
    logic [31:0] address;
    logic [3:0]  entry_index;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] result_address;
    logic [16:0] blk_bytes;
    logic [4:0]  block_count;
    logic [16:0] bytes_used;
    logic [16:0] bytes_free;
  } rsp_t;

  // passed from cell to cell: overlap seen, first address match
  typedef struct packed {
    logic              ovl;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [16:0]       len;
  } chain_t;

endpackage

### hdl/bta_cell.sv
// ----------------------------------------------------------------------------
// bta_cell - one table slot
// holds start and length, checks the candidate span and the lookup address
// ----------------------------------------------------------------------------
module bta_cell #(
  parameter int unsigned SLOT = 0
) (
  input  logic            clk_i,
  input  logic            valid_i,
  input  logic            load_i,
  input  logic [31:0]     load_start_i,
  input  logic [16:0]     load_len_i,
  input  logic [33:0]     cand_i,
  input  logic [16:0]     size_i,
  input  logic [31:0]     addr_i,
  input  bta_pkg::chain_t chain_i,
  output bta_pkg::chain_t chain_o,
  output logic [31:0]     start_o,
  output logic [16:0]     len_o
);

  logic [31:0] start_q;
  logic [16:0] len_q;
  logic [33:0] cell_end;
  logic        ovl;
  logic        hit;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      start_q <= load_start_i;
      len_q   <= load_len_i;
    end
  end

  assign cell_end = {2'b00, start_q} + {17'd0, len_q};
  assign ovl = valid_i && (cand_i < cell_end) &&
               ({2'b00, start_q} < cand_i + {17'd0, size_i});
  assign hit = valid_i && (start_q == addr_i);

  always_comb begin
    chain_o     = chain_i;
    chain_o.ovl = chain_i.ovl | ovl;
    // lowest matching slot wins
    if (!chain_i.found && hit) begin
      chain_o.found = 1'b1;
      chain_o.slot  = bta_pkg::SLOT_W'(SLOT);
      chain_o.len   = len_q;
    end
  end

  assign start_o = start_q;
  assign len_o   = len_q;

endmodule

### hdl/block_table_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// block_table_first_fit_allocator - first fit allocator over a block table
// row of slot cells plus a sequencer stepping through candidate addresses
// ----------------------------------------------------------------------------
// Each request gives one response. Free, size query and entry read are
// answered from a single evaluation. Allocate tests one candidate
// address per cycle against every slot at once, walking base, base+size,
// base+2*size and so on, until a candidate fits or overruns the heap;
// the worst case is HEAP_BYTES/size + 1 candidates when the heap is crowded.
// A new request is taken once the previous response has been handed to the
// output register, which holds it until the consumer takes it.
module block_table_first_fit_allocator #(
  parameter logic [31:0] HEAP_BASE     = bta_pkg::HEAP_BASE_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bta_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bta_pkg::rsp_t out_data_o
);

  // table depth and heap size are tied to the request and response field widths
  localparam int unsigned TABLE_ENTRIES = bta_pkg::TABLE_ENTRIES_DEF;
  localparam int unsigned HEAP_BYTES    = bta_pkg::HEAP_BYTES_DEF;
  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned USED_W = $clog2(HEAP_BYTES + 1);
  localparam int unsigned XI_W   = CNT_W + 4;
  localparam logic [33:0] BASE   = {2'b00, HEAP_BASE};
  localparam logic [33:0] HEND   = {2'b00, HEAP_BASE} + 34'(HEAP_BYTES);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e          state_q;
  bta_pkg::req_t   req_q;
  logic [33:0]     cand_q, cand_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [USED_W-1:0] used_q, used_d;
  bta_pkg::rsp_t   out_q, rsp;
  logic            out_valid_q;

  // cell row wiring
  bta_pkg::chain_t chain [TABLE_ENTRIES+1];
  logic [31:0]     cell_start [TABLE_ENTRIES];
  logic [16:0]     cell_len   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] cell_load;
  logic [31:0]     wr_start;
  logic [16:0]     wr_len;
  logic [IDX_W-1:0] wr_slot;
  logic            wr_en;

  logic            done, push, commit;
  logic [CNT_W-1:0] last;
  logic [XI_W-1:0] idx_ext;
  logic            idx_ok;

  assign chain[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    bta_cell #(.SLOT(i)) u_cell (
      .clk_i        (clk_i),
      .valid_i      (cnt_q > CNT_W'(i)),
      .load_i       (cell_load[i]),
      .load_start_i (wr_start),
      .load_len_i   (wr_len),
      .cand_i       (cand_q),
      .size_i       (req_q.req_size),
      .addr_i       (req_q.address),
      .chain_i      (chain[i]),
      .chain_o      (chain[i+1]),
      .start_o      (cell_start[i]),
      .len_o        (cell_len[i])
    );
    assign cell_load[i] = wr_en && (wr_slot == IDX_W'(i));
  end

  assign last    = cnt_q - CNT_W'(1);
  assign idx_ext = XI_W'(req_q.entry_index);
  assign idx_ok  = idx_ext < XI_W'(cnt_q);

  // one evaluation per cycle of the current request
  always_comb begin
    bta_pkg::chain_t res;
    res      = chain[TABLE_ENTRIES];
    done     = 1'b1;
    commit   = 1'b0;
    cand_d   = cand_q;
    cnt_d    = cnt_q;
    used_d   = used_q;
    wr_start = cell_start[last[IDX_W-1:0]];
    wr_len   = cell_len[last[IDX_W-1:0]];
    wr_slot  = res.slot[IDX_W-1:0];
    rsp      = '0;
    rsp.status = bta_pkg::ST_OK;
    case (req_q.op)
      bta_pkg::OP_ALLOC: begin
        wr_start = cand_q[31:0];
        wr_len   = req_q.req_size;
        wr_slot  = cnt_q[IDX_W-1:0];
        if (req_q.req_size == '0) begin
          rsp.status = bta_pkg::ST_ZERO;
        end else if (cnt_q == CNT_W'(TABLE_ENTRIES)) begin
          rsp.status = bta_pkg::ST_FULL;
        end else if (cand_q + {17'd0, req_q.req_size} > HEND) begin
          rsp.status = bta_pkg::ST_NOSPACE;
        end else if (res.ovl) begin
          // next candidate along
          done   = 1'b0;
          cand_d = cand_q + {17'd0, req_q.req_size};
        end else begin
          commit = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
          used_d = used_q + USED_W'(req_q.req_size);
          rsp.result_address = cand_q[31:0];
        end
      end
      bta_pkg::OP_FREE: begin
        if (res.found) begin
          commit = 1'b1;
          cnt_d  = last;
          used_d = used_q - USED_W'(res.len);
        end else begin
          rsp.status = bta_pkg::ST_NOTFOUND;
        end
      end
      bta_pkg::OP_QUERY: begin
        if (res.found) begin
          rsp.blk_bytes = res.len;
        end else begin
          rsp.status = bta_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        if (idx_ok) begin
          rsp.result_address = cell_start[idx_ext[IDX_W-1:0]];
          rsp.blk_bytes      = cell_len[idx_ext[IDX_W-1:0]];
        end else begin
          rsp.status = bta_pkg::ST_NOTFOUND;
        end
      end
    endcase
    rsp.block_count = 5'(cnt_d);
    rsp.bytes_used  = 17'(used_d);
    rsp.bytes_free  = 17'(USED_W'(HEAP_BYTES) - used_d);
  end

  assign push  = (state_q == S_EXEC) && done && (!out_valid_q || out_ready_i);
  assign wr_en = push && commit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // sequencer, table counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      used_q      <= '0;
      req_q       <= '0;
      cand_q      <= '0;
      out_q       <= '0;
    end else begin
      // output register: loaded on push, emptied when taken
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_data_i;
            cand_q  <= BASE;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          cand_q <= cand_d;
          if (push) begin
            out_q       <= rsp;
            state_q     <= S_IDLE;
            if (commit) begin
              cnt_q  <= cnt_d;
              used_q <= used_d;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // table never holds more blocks than slots
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_ENTRIES))
    else $error("block count above table size");

  // used bytes stay within the heap
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= USED_W'(HEAP_BYTES))
    else $error("used bytes above heap size");

  // a successful allocate adds exactly one block
  a_alloc_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && req_q.op == bta_pkg::OP_ALLOC) |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("allocate did not add one block");

  // no new request while one is in flight
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && !push) |=> state_q == S_EXEC)
    else $error("request dropped before its response");

endmodule
